>>> src/p2_triangle_basis_at_point_assert.svh
// ----------------------------------------------------------------------------
// P2 triangle basis assertion macros
// Shared property forms for the result channel checker.
// ----------------------------------------------------------------------------
`ifndef P2_TRIANGLE_BASIS_AT_POINT_ASSERT_SVH
`define P2_TRIANGLE_BASIS_AT_POINT_ASSERT_SVH

// same-cycle implication
`define P2TB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define P2TB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/p2tb_pkg.sv
// ----------------------------------------------------------------------------
// P2 triangle basis package
// Shared constants, types and saturation helpers.
// ----------------------------------------------------------------------------
package p2tb_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int OUT_W           = 32;
   localparam int QB              = 42;   // quotient bits kept by the divider
   localparam int NUM_BASIS       = 6;
   localparam int RSP_DATA_W      = 104;
   localparam int RND_W           = 67;

   localparam logic [QB-1:0] QCAP       = QB'(1) << 40;
   localparam logic [2:0]    BASIS_LAST = 3'd5;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } side_type;

   typedef struct packed {
      logic [OUT_W-1:0] grad_y;
      logic [OUT_W-1:0] grad_x;
      logic [OUT_W-1:0] value;
   } rslt_type;

   function automatic logic [OUT_W-1:0] sat36(input logic signed [35:0] v);
      logic [OUT_W-1:0] r;
      if (v > 36'sh07FFFFFFF) r = 32'h7FFFFFFF;
      else if (v < -36'sh080000000) r = 32'h80000000;
      else r = v[OUT_W-1:0];
      return r;
   endfunction

   // apply sign to a magnitude and saturate
   function automatic logic [OUT_W-1:0] sign_sat(input logic [RND_W-1:0] m, input logic neg);
      logic [OUT_W-1:0] r;
      logic [RND_W-1:0] nm;
      nm = ~m + RND_W'(1);
      if (neg) r = (m > RND_W'(64'h80000000)) ? 32'h80000000 : nm[OUT_W-1:0];
      else r = (m > RND_W'(64'h7FFFFFFF)) ? 32'h7FFFFFFF : m[OUT_W-1:0];
      return r;
   endfunction

endpackage

>>> src/p2tb_div.sv
// ----------------------------------------------------------------------------
// P2 triangle basis divider
// Three-lane restoring divider, one quotient bit per stage after the first, quotient capped.
// ----------------------------------------------------------------------------
module p2tb_div #(
   parameter int MW        = 69,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [MW-1:0]            nm_i [0:2],
   input  logic [MW-1:0]            dm_i,
   input  p2tb_pkg::side_type       side_i,
   output logic                     out_valid,
   output logic [p2tb_pkg::QB-1:0]  q_o [0:2],
   output p2tb_pkg::side_type       side_o
);
   import p2tb_pkg::*;

   localparam int NW = MW + FRAC_BITS + 1;

   logic [QB:0]     vld_ff;
   logic [MW-1:0]   rem_ff [0:QB][0:2];
   logic [MW-1:0]   rem_in [0:QB][0:2];
   logic [QB-1:0]   low_ff [0:QB][0:2];
   logic [QB-1:0]   low_in [0:QB][0:2];
   logic [QB-1:0]   q_ff   [0:QB][0:2];
   logic [QB-1:0]   q_in   [0:QB][0:2];
   logic [2:0]      ov_ff  [0:QB];
   logic [2:0]      ov_in;
   logic [MW-1:0]   dm_ff  [0:QB];
   side_type        side_ff [0:QB];

   always_comb begin
      logic [NW-1:0] nf;
      logic [NW-1:0] top;
      logic [MW:0]   r2;
      logic          ge;
      for (int l = 0; l < 3; l++) begin
         nf = {nm_i[l], (FRAC_BITS + 1)'(0)};
         top = nf >> QB;
         ov_in[l] = top >= NW'(dm_i);
         rem_in[0][l] = ov_in[l] ? '0 : top[MW-1:0];
         low_in[0][l] = nf[QB-1:0];
         q_in[0][l] = '0;
      end
      for (int k = 1; k <= QB; k++) begin
         for (int l = 0; l < 3; l++) begin
            r2 = {rem_ff[k-1][l], low_ff[k-1][l][QB-1]};
            ge = r2 >= {1'b0, dm_ff[k-1]};
            rem_in[k][l] = ge ? MW'(r2 - {1'b0, dm_ff[k-1]}) : r2[MW-1:0];
            low_in[k][l] = {low_ff[k-1][l][QB-2:0], 1'b0};
            q_in[k][l] = {q_ff[k-1][l][QB-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QB; k++) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               low_ff[k][l] <= low_in[k][l];
               q_ff[k][l]   <= q_in[k][l];
            end
         end
         ov_ff[0]   <= ov_in;
         dm_ff[0]   <= dm_i;
         side_ff[0] <= side_i;
         for (int k = 1; k <= QB; k++) begin
            ov_ff[k]   <= ov_ff[k-1];
            dm_ff[k]   <= dm_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (ov_ff[QB][l] || q_ff[QB][l] > QCAP) q_o[l] = QCAP;
         else q_o[l] = q_ff[QB][l];
      end
   end

   assign out_valid = vld_ff[QB];
   assign side_o    = side_ff[QB];

endmodule

>>> src/p2_triangle_basis_at_point.sv
// ----------------------------------------------------------------------------
// P2 triangle basis at point
// Quadratic Lagrange shape functions and reference gradients at a point.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_ carries the query point and three triangle vertices,
//   signed fixed point. Each request yields six responses on rsp_, basis 0..2
//   (vertex functions) then 3..5 (edge functions), tlast on the sixth.
//   tuser flags a zero-area triangle; its values and gradients are zero.
// Pipeline: six stages of cross products and magnitudes, a 43-stage
//   divider (one quotient bit per stage after the first), four stages
//   of products and rounding, and the output buffer.
// Throughput: the pipeline takes one request per cycle while req_tready is
//   high; the response port moves one beat per cycle while rsp_tready is high.
// Stall: when rsp_tready is low the output buffer holds its beat and the
//   pipeline freezes once its last stage is full; req_tready drops then.
// Reset: synchronous, clears all valid bits and the output buffer's busy flag and beat counter.
// ----------------------------------------------------------------------------
module p2_triangle_basis_at_point #(
   parameter int COORD_WIDTH = p2tb_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = p2tb_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
   input  logic [8*COORD_WIDTH-1:0]          req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // basis_index[2:0], shape_value[34:3], grad_ref_x[66:35], grad_ref_y[98:67], zero pad
   output logic [p2tb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // degenerate
   output logic                              rsp_tuser
);
   import p2tb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * CW + 2;
   localparam int MW = 2 * CW + 5;
   localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
   localparam logic signed [35:0] ONE36 = 36'sd1 <<< FRAC_BITS;
   localparam logic [RND_W-1:0]   HALF_V = RND_W'(1) << (FRAC_BITS - 1);
   localparam logic [RND_W-1:0]   HALF_E = RND_W'(1) << (FRAC_BITS - 3);

   logic en;
   logic load;

   // stage valids
   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff, vld_f_ff;
   logic vld_g_ff, vld_h_ff, vld_i_ff, vld_j_ff;
   logic div_vld;

   logic signed [CW-1:0] crd_ff [0:7];
   logic signed [CW:0]   ext    [0:7];
   logic signed [CW:0]   dif_in [0:2][0:3];
   logic signed [CW:0]   dif_ff [0:2][0:3];
   logic signed [PW-1:0] prd_ff [0:2][0:1];
   logic signed [MW-1:0] crs_ff [0:2];
   logic signed [MW-1:0] crs_e_ff [0:2];
   logic signed [MW-1:0] det_ff;
   logic [MW-1:0]        nm_ff [0:2];
   logic [MW-1:0]        dm_ff;
   side_type             sd_f_ff;
   logic [QB-1:0]        q_div [0:2];
   side_type             sd_div;
   logic signed [OUT_W-1:0] l_ff [0:2];
   logic                 dg_g_ff, dg_h_ff, dg_i_ff, dg_j_ff;
   logic signed [65:0]   pr_ff [0:5];
   logic [OUT_W-1:0]     gr_ff [0:5][0:1];
   logic [OUT_W-1:0]     gr_i_ff [0:5][0:1];
   logic [65:0]          mg_ff [0:5];
   logic [5:0]           ng_ff;
   rslt_type             res_ff [0:5];
   rslt_type             buf_ff [0:5];
   logic                 busy_ff;
   logic [2:0]           cnt_ff;
   logic                 dgn_ff;

   assign load       = !busy_ff || (rsp_tready && cnt_ff == BASIS_LAST);
   assign en         = !vld_j_ff || load;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         vld_f_ff <= 1'b0;
         vld_g_ff <= 1'b0;
         vld_h_ff <= 1'b0;
         vld_i_ff <= 1'b0;
         vld_j_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= req_tvalid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         vld_d_ff <= vld_c_ff;
         vld_e_ff <= vld_d_ff;
         vld_f_ff <= vld_e_ff;
         vld_g_ff <= div_vld;
         vld_h_ff <= vld_g_ff;
         vld_i_ff <= vld_h_ff;
         vld_j_ff <= vld_i_ff;
      end
   end

   // cross product operands: 0 px, 1 py, 2 q0x, 3 q0y, 4 q1x, 5 q1y, 6 q2x, 7 q2y
   always_comb begin
      for (int k = 0; k < 8; k++) ext[k] = {crd_ff[k][CW-1], crd_ff[k]};
      dif_in[0][0] = ext[4] - ext[0];
      dif_in[0][1] = ext[5] - ext[1];
      dif_in[0][2] = ext[6] - ext[0];
      dif_in[0][3] = ext[7] - ext[1];
      dif_in[1][0] = ext[0] - ext[2];
      dif_in[1][1] = ext[1] - ext[3];
      dif_in[1][2] = ext[6] - ext[2];
      dif_in[1][3] = ext[7] - ext[3];
      dif_in[2][0] = ext[4] - ext[2];
      dif_in[2][1] = ext[5] - ext[3];
      dif_in[2][2] = ext[0] - ext[2];
      dif_in[2][3] = ext[1] - ext[3];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 8; k++) crd_ff[k] <= req_tdata[k*CW +: CW];
         for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 4; k++) dif_ff[s][k] <= dif_in[s][k];
            prd_ff[s][0] <= PW'(dif_ff[s][0]) * PW'(dif_ff[s][3]);
            prd_ff[s][1] <= PW'(dif_ff[s][1]) * PW'(dif_ff[s][2]);
            crs_ff[s]    <= MW'(prd_ff[s][0]) - MW'(prd_ff[s][1]);
            crs_e_ff[s]  <= crs_ff[s];
            nm_ff[s]     <= crs_e_ff[s][MW-1] ? MW'(-crs_e_ff[s]) : MW'(crs_e_ff[s]);
            sd_f_ff.neg[s] <= crs_e_ff[s][MW-1] ^ det_ff[MW-1];
         end
         det_ff     <= crs_ff[0] + crs_ff[1] + crs_ff[2];
         dm_ff      <= det_ff[MW-1] ? MW'(-det_ff) : MW'(det_ff);
         sd_f_ff.degen <= det_ff == '0;
      end
   end

   p2tb_div #(
      .MW        (MW),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_f_ff),
      .nm_i      (nm_ff),
      .dm_i      (dm_ff),
      .side_i    (sd_f_ff),
      .out_valid (div_vld),
      .q_o       (q_div),
      .side_o    (sd_div)
   );

   // barycentric coordinates: round quotient, sign, saturate; zero for a degenerate triangle
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < 3; s++) begin
            l_ff[s] <= sd_div.degen ? '0
                       : sign_sat(RND_W'((QB + 1)'(q_div[s]) + (QB + 1)'(1)) >> 1,
                                  sd_div.neg[s]);
         end
         dg_g_ff <= sd_div.degen;
      end
   end

   // products and gradients
   always_ff @(posedge clock) begin
      logic signed [33:0] lw [0:2];
      logic signed [35:0] g4 [0:2];
      logic signed [35:0] f4 [0:2];
      if (en) begin
         for (int s = 0; s < 3; s++) begin
            lw[s] = (34'(l_ff[s]) <<< 1) - ONE34;
            f4[s] = 36'(l_ff[s]) <<< 2;
            g4[s] = f4[s] - ONE36;
            pr_ff[s] <= 66'(l_ff[s]) * 66'(lw[s]);
         end
         pr_ff[3] <= 66'(l_ff[1]) * 66'(l_ff[2]);
         pr_ff[4] <= 66'(l_ff[2]) * 66'(l_ff[0]);
         pr_ff[5] <= 66'(l_ff[0]) * 66'(l_ff[1]);
         gr_ff[0][0] <= sat36(-g4[0]);
         gr_ff[0][1] <= sat36(-g4[0]);
         gr_ff[1][0] <= sat36(g4[1]);
         gr_ff[1][1] <= '0;
         gr_ff[2][0] <= '0;
         gr_ff[2][1] <= sat36(g4[2]);
         gr_ff[3][0] <= sat36(f4[2]);
         gr_ff[3][1] <= sat36(f4[1]);
         gr_ff[4][0] <= sat36(-f4[2]);
         gr_ff[4][1] <= sat36(f4[0] - f4[2]);
         gr_ff[5][0] <= sat36(f4[0] - f4[1]);
         gr_ff[5][1] <= sat36(-f4[1]);
         dg_h_ff <= dg_g_ff;
      end
   end

   // magnitudes, then round half away from zero and saturate; zero for a degenerate triangle
   always_ff @(posedge clock) begin
      logic [RND_W-1:0] r;
      if (en) begin
         for (int b = 0; b < NUM_BASIS; b++) begin
            ng_ff[b]    <= pr_ff[b][65];
            mg_ff[b]    <= pr_ff[b][65] ? 66'(-pr_ff[b]) : 66'(pr_ff[b]);
            gr_i_ff[b]  <= gr_ff[b];
         end
         dg_i_ff <= dg_h_ff;
         for (int b = 0; b < NUM_BASIS; b++) begin
            if (b < 3) r = (RND_W'(mg_ff[b]) + HALF_V) >> FRAC_BITS;
            else r = (RND_W'(mg_ff[b]) + HALF_E) >> (FRAC_BITS - 2);
            res_ff[b].value  <= dg_i_ff ? '0 : sign_sat(r, ng_ff[b]);
            res_ff[b].grad_x <= dg_i_ff ? '0 : gr_i_ff[b][0];
            res_ff[b].grad_y <= dg_i_ff ? '0 : gr_i_ff[b][1];
         end
         dg_j_ff <= dg_i_ff;
      end
   end

   // output buffer: six beats per request
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load && vld_j_ff) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff && rsp_tready) begin
         busy_ff <= cnt_ff != BASIS_LAST;
         cnt_ff  <= (cnt_ff == BASIS_LAST) ? '0 : cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && vld_j_ff) begin
         buf_ff <= res_ff;
         dgn_ff <= dg_j_ff;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = cnt_ff == BASIS_LAST;
   assign rsp_tuser  = dgn_ff;
   assign rsp_tdata  = {5'b0, buf_ff[cnt_ff].grad_y, buf_ff[cnt_ff].grad_x,
                        buf_ff[cnt_ff].value, cnt_ff};

endmodule

>>> src/p2tb_checker.sv
// ----------------------------------------------------------------------------
// P2 triangle basis checker
// Port-level checks on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "p2_triangle_basis_at_point_assert.svh"

module p2tb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [p2tb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              rsp_tuser
);
   import p2tb_pkg::*;

   `P2TB_ASSERT_NOW(a_last_index, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == BASIS_LAST, "tlast not on last basis")
   `P2TB_ASSERT_NOW(a_index_range, rsp_tvalid, rsp_tdata[2:0] <= BASIS_LAST, "basis index out of range")
   `P2TB_ASSERT_NEXT(a_index_step, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tdata[2:0] == $past(rsp_tdata[2:0]) + 3'd1 && rsp_tuser == $past(rsp_tuser), "run broken")
   `P2TB_ASSERT_NOW(a_degen_zero, rsp_tvalid && rsp_tuser, rsp_tdata[98:3] == '0, "degenerate result not zero")
   `P2TB_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

endmodule

bind p2_triangle_basis_at_point p2tb_checker u_p2tb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
